@@ rtl/spi_pkg.sv @@
// ----------------------------------------------------------------------------
// spi_pkg
// Shared widths, status codes and stage types for the segment pair
// intersection core.
// ----------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

	// coordinate and vertex number widths
	localparam int CW = 24;
	localparam int IW = 16;

	// quotient magnitude bits, one divider cell per bit
	localparam int QW = CW;
	// product of two coordinates
	localparam int PW = 2 * CW;
	// signed denominator and signed numerator widths
	localparam int DW = 2 * CW + 3;
	localparam int NW = 3 * CW + 3;

	// result status codes
	localparam logic [1:0] ST_NONE     = 2'd0;
	localparam logic [1:0] ST_CROSS    = 2'd1;
	localparam logic [1:0] ST_PARALLEL = 2'd2;
	localparam logic [1:0] ST_SHARED   = 2'd3;

	// one input request
	typedef struct packed {
		logic [CW-1:0] a_start_x;
		logic [CW-1:0] a_start_y;
		logic [CW-1:0] a_end_x;
		logic [CW-1:0] a_end_y;
		logic [CW-1:0] b_start_x;
		logic [CW-1:0] b_start_y;
		logic [CW-1:0] b_end_x;
		logic [CW-1:0] b_end_y;
		logic [IW-1:0] a_start_id;
		logic [IW-1:0] a_end_id;
		logic [IW-1:0] b_start_id;
		logic [IW-1:0] b_end_id;
	} spi_req_t;

	// state carried along the divider chain
	typedef struct packed {
		logic [1:0]    status;
		logic          neg_x;
		logic          neg_y;
		logic [NW-1:0] dsh;
		logic [NW-1:0] rem_x;
		logic [NW-1:0] rem_y;
		logic [QW-1:0] q_x;
		logic [QW-1:0] q_y;
	} spi_div_t;

endpackage

`default_nettype wire

@@ rtl/segment_pair_intersection_core.sv @@
// ----------------------------------------------------------------------------
// segment_pair_intersection_core
// Tests two segments for a crossing and gives the crossing point rounded
// to the nearest whole unit, or a shared vertex / parallel / no crossing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with the eight endpoint coordinates
//   and four vertex numbers. Output channel: out_valid / out_stall with
//   status, crosses, cross_x and cross_y. One result per request, in order.
//   A request passes five arithmetic stages (coefficients, side tests,
//   denominator, numerators, rounding offset), one divider cell per
//   quotient bit (24 cells), and the output register.
//   Throughput is one request per cycle while out_stall is low; every stage
//   is pipelined; each divider cell gives one quotient bit per coordinate.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling until each holds a request; in_stall
//   rises only when the whole pipeline is full.
//   Reset clears all valid flags; the pipeline is empty after reset and
//   accepts a request in the first cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_pair_intersection_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [spi_pkg::CW-1:0] a_start_x,
	input  logic signed [spi_pkg::CW-1:0] a_start_y,
	input  logic signed [spi_pkg::CW-1:0] a_end_x,
	input  logic signed [spi_pkg::CW-1:0] a_end_y,
	input  logic signed [spi_pkg::CW-1:0] b_start_x,
	input  logic signed [spi_pkg::CW-1:0] b_start_y,
	input  logic signed [spi_pkg::CW-1:0] b_end_x,
	input  logic signed [spi_pkg::CW-1:0] b_end_y,
	input  logic [spi_pkg::IW-1:0]      a_start_id,
	input  logic [spi_pkg::IW-1:0]      a_end_id,
	input  logic [spi_pkg::IW-1:0]      b_start_id,
	input  logic [spi_pkg::IW-1:0]      b_end_id,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic                        crosses,
	output logic signed [spi_pkg::CW-1:0] cross_x,
	output logic signed [spi_pkg::CW-1:0] cross_y
);
	import spi_pkg::*;

	// request packing
	spi_req_t req;
	logic     req_ready;

	always_comb begin
		req.a_start_x  = a_start_x;
		req.a_start_y  = a_start_y;
		req.a_end_x    = a_end_x;
		req.a_end_y    = a_end_y;
		req.b_start_x  = b_start_x;
		req.b_start_y  = b_start_y;
		req.b_end_x    = b_end_x;
		req.b_end_y    = b_end_y;
		req.a_start_id = a_start_id;
		req.a_end_id   = a_end_id;
		req.b_start_id = b_start_id;
		req.b_end_id   = b_end_id;
	end

	assign in_stall = !req_ready;

	// chain links: entry 0 from the front end, entry QW out of the last cell
	spi_div_t link_d [QW+1];
	logic     link_v [QW+1];
	logic     link_r [QW+1];

	spi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (req_ready),
		.req       (req),
		.div_valid (link_v[0]),
		.div       (link_d[0]),
		.div_ready (link_r[0])
	);

	for (genvar i = 0; i < QW; i++) begin : g_cell
		spi_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_v[i]),
			.up_ready (link_r[i]),
			.up       (link_d[i]),
			.dn_valid (link_v[i+1]),
			.dn_ready (link_r[i+1]),
			.dn       (link_d[i+1])
		);
	end

	// output register with signed quotient
	logic                 out_valid_q;
	logic                 out_ready;
	logic [1:0]           status_q;
	logic                 crosses_q;
	logic signed [CW-1:0] cross_x_q, cross_y_q;
	logic                 hit;
	spi_div_t             fin;

	assign fin          = link_d[QW];
	assign hit          = fin.status == ST_CROSS;
	assign out_ready    = !out_valid_q || !out_stall;
	assign link_r[QW]   = out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= link_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready) begin
			status_q  <= fin.status;
			crosses_q <= hit;
			cross_x_q <= !hit ? '0 : (fin.neg_x ? -fin.q_x : fin.q_x);
			cross_y_q <= !hit ? '0 : (fin.neg_y ? -fin.q_y : fin.q_y);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign crosses   = crosses_q;
	assign cross_x   = cross_x_q;
	assign cross_y   = cross_y_q;

	// crossing flag agrees with status
	a_crosses_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (crosses == (status == ST_CROSS)))
		else $error("crosses flag disagrees with status");

	// point is zero unless a crossing is reported
	a_point_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_CROSS) |-> (cross_x == '0 && cross_y == '0))
		else $error("crossing point not zero without a crossing");

	// an empty output register means nothing can hold up the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

endmodule

`default_nettype wire

@@ rtl/spi_front.sv @@
// ----------------------------------------------------------------------------
// spi_front
// Line coefficients, side tests, denominator and rounded numerators,
// five pipeline stages feeding the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  spi_pkg::spi_req_t req,
	output logic              div_valid,
	output spi_pkg::spi_div_t div,
	input  logic              div_ready
);
	import spi_pkg::*;

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	assign rdy_s5    = !v_s5 || div_ready;
	assign rdy_s4    = !v_s4 || rdy_s5;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign req_ready = rdy_s1;
	assign div_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= req_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: shared vertex test, coefficient differences, cross products
	logic signed [CW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
	logic                 sh_c;
	logic signed [CW:0]   a1_c, b1_c, a2_c, b2_c;
	logic signed [PW-1:0] p21_c, p12_c, p43_c, p34_c;

	assign x1 = req.a_start_x;
	assign y1 = req.a_start_y;
	assign x2 = req.a_end_x;
	assign y2 = req.a_end_y;
	assign x3 = req.b_start_x;
	assign y3 = req.b_start_y;
	assign x4 = req.b_end_x;
	assign y4 = req.b_end_y;

	assign sh_c = (req.a_start_id == req.b_start_id) || (req.a_start_id == req.b_end_id) ||
		(req.a_end_id == req.b_start_id) || (req.a_end_id == req.b_end_id);

	assign a1_c  = {y2[CW-1], y2} - {y1[CW-1], y1};
	assign b1_c  = {x1[CW-1], x1} - {x2[CW-1], x2};
	assign a2_c  = {y4[CW-1], y4} - {y3[CW-1], y3};
	assign b2_c  = {x3[CW-1], x3} - {x4[CW-1], x4};
	assign p21_c = x2 * y1;
	assign p12_c = x1 * y2;
	assign p43_c = x4 * y3;
	assign p34_c = x3 * y4;

	logic signed [CW-1:0] x1_s1, y1_s1, x2_s1, y2_s1, x3_s1, y3_s1, x4_s1, y4_s1;
	logic                 sh_s1;
	logic signed [CW:0]   a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [PW-1:0] p21_s1, p12_s1, p43_s1, p34_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			x1_s1  <= x1;
			y1_s1  <= y1;
			x2_s1  <= x2;
			y2_s1  <= y2;
			x3_s1  <= x3;
			y3_s1  <= y3;
			x4_s1  <= x4;
			y4_s1  <= y4;
			sh_s1  <= sh_c;
			a1_s1  <= a1_c;
			b1_s1  <= b1_c;
			a2_s1  <= a2_c;
			b2_s1  <= b2_c;
			p21_s1 <= p21_c;
			p12_s1 <= p12_c;
			p43_s1 <= p43_c;
			p34_s1 <= p34_c;
		end
	end

	// stage 2: line constants and side test products
	logic signed [PW:0]   c1_c, c2_c;
	logic signed [PW:0]   m3a_c, m3b_c, m4a_c, m4b_c, m1a_c, m1b_c, m2a_c, m2b_c;
	logic signed [PW+1:0] d1_c, d2_c;

	assign c1_c  = {p21_s1[PW-1], p21_s1} - {p12_s1[PW-1], p12_s1};
	assign c2_c  = {p43_s1[PW-1], p43_s1} - {p34_s1[PW-1], p34_s1};
	assign m3a_c = a1_s1 * x3_s1;
	assign m3b_c = b1_s1 * y3_s1;
	assign m4a_c = a1_s1 * x4_s1;
	assign m4b_c = b1_s1 * y4_s1;
	assign m1a_c = a2_s1 * x1_s1;
	assign m1b_c = b2_s1 * y1_s1;
	assign m2a_c = a2_s1 * x2_s1;
	assign m2b_c = b2_s1 * y2_s1;
	assign d1_c  = a1_s1 * b2_s1;
	assign d2_c  = a2_s1 * b1_s1;

	logic                 sh_s2;
	logic signed [CW:0]   a1_s2, b1_s2, a2_s2, b2_s2;
	logic signed [PW:0]   c1_s2, c2_s2;
	logic signed [PW:0]   m3a_s2, m3b_s2, m4a_s2, m4b_s2, m1a_s2, m1b_s2, m2a_s2, m2b_s2;
	logic signed [PW+1:0] d1_s2, d2_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			sh_s2  <= sh_s1;
			a1_s2  <= a1_s1;
			b1_s2  <= b1_s1;
			a2_s2  <= a2_s1;
			b2_s2  <= b2_s1;
			c1_s2  <= c1_c;
			c2_s2  <= c2_c;
			m3a_s2 <= m3a_c;
			m3b_s2 <= m3b_c;
			m4a_s2 <= m4a_c;
			m4b_s2 <= m4b_c;
			m1a_s2 <= m1a_c;
			m1b_s2 <= m1b_c;
			m2a_s2 <= m2a_c;
			m2b_s2 <= m2b_c;
			d1_s2  <= d1_c;
			d2_s2  <= d2_c;
		end
	end

	// stage 3: side values, status, denominator, split numerator products
	logic signed [PW+2:0]   r1_c, r2_c, r3_c, r4_c;
	logic                   sep_a, sep_b;
	logic signed [DW-1:0]   den_c;
	logic [1:0]             st_c;
	logic signed [CW:0]     c1h, c1l, c2h, c2l;
	logic signed [2*CW+1:0] hx1_c, lx1_c, hx2_c, lx2_c, hy1_c, ly1_c, hy2_c, ly2_c;

	assign r3_c  = m3a_s2 + m3b_s2 + c1_s2;
	assign r4_c  = m4a_s2 + m4b_s2 + c1_s2;
	assign r1_c  = m1a_s2 + m1b_s2 + c2_s2;
	assign r2_c  = m2a_s2 + m2b_s2 + c2_s2;
	assign sep_a = (r3_c != '0) && (r4_c != '0) && (r3_c[PW+2] == r4_c[PW+2]);
	assign sep_b = (r1_c != '0) && (r2_c != '0) && (r1_c[PW+2] == r2_c[PW+2]);
	assign den_c = d1_s2 - d2_s2;

	always_comb begin
		if (sh_s2)
			st_c = ST_SHARED;
		else if (sep_a || sep_b)
			st_c = ST_NONE;
		else if (den_c == '0)
			st_c = ST_PARALLEL;
		else
			st_c = ST_CROSS;
	end

	// line constants split into a signed high part and an unsigned low part
	assign c1h = c1_s2[PW:CW];
	assign c2h = c2_s2[PW:CW];
	assign c1l = {1'b0, c1_s2[CW-1:0]};
	assign c2l = {1'b0, c2_s2[CW-1:0]};

	assign hx1_c = b1_s2 * c2h;
	assign lx1_c = b1_s2 * c2l;
	assign hx2_c = b2_s2 * c1h;
	assign lx2_c = b2_s2 * c1l;
	assign hy1_c = a2_s2 * c1h;
	assign ly1_c = a2_s2 * c1l;
	assign hy2_c = a1_s2 * c2h;
	assign ly2_c = a1_s2 * c2l;

	logic [1:0]             st_s3;
	logic signed [DW-1:0]   den_s3;
	logic signed [2*CW+1:0] hx1_s3, lx1_s3, hx2_s3, lx2_s3, hy1_s3, ly1_s3, hy2_s3, ly2_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			st_s3  <= st_c;
			den_s3 <= den_c;
			hx1_s3 <= hx1_c;
			lx1_s3 <= lx1_c;
			hx2_s3 <= hx2_c;
			lx2_s3 <= lx2_c;
			hy1_s3 <= hy1_c;
			ly1_s3 <= ly1_c;
			hy2_s3 <= hy2_c;
			ly2_s3 <= ly2_c;
		end
	end

	// stage 4: full numerators and denominator magnitude
	logic signed [NW-1:0] hxw, lxw, hyw, lyw, nx_c, ny_c;
	logic [DW-1:0]        dmag_c;

	assign hxw    = hx1_s3 - hx2_s3;
	assign lxw    = lx1_s3 - lx2_s3;
	assign hyw    = hy1_s3 - hy2_s3;
	assign lyw    = ly1_s3 - ly2_s3;
	assign nx_c   = (hxw <<< CW) + lxw;
	assign ny_c   = (hyw <<< CW) + lyw;
	assign dmag_c = den_s3[DW-1] ? -den_s3 : den_s3;

	logic [1:0]           st_s4;
	logic signed [NW-1:0] nx_s4, ny_s4;
	logic [DW-1:0]        dmag_s4;
	logic                 dneg_s4;

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			st_s4   <= st_s3;
			nx_s4   <= nx_c;
			ny_s4   <= ny_c;
			dmag_s4 <= dmag_c;
			dneg_s4 <= den_s3[DW-1];
		end
	end

	// stage 5: rounding offset added away from zero, divisor aligned to top bit
	logic [DW-1:0]  off;
	logic [NW-1:0]  ax, ay, off_w, dmag_w;
	spi_div_t       div_c;
	spi_div_t       div_s5;

	assign off    = dmag_s4 >> 1;
	assign off_w  = {{(NW-DW){1'b0}}, off};
	assign dmag_w = {{(NW-DW){1'b0}}, dmag_s4};
	assign ax     = nx_s4[NW-1] ? -nx_s4 : nx_s4;
	assign ay     = ny_s4[NW-1] ? -ny_s4 : ny_s4;

	always_comb begin
		div_c.status = st_s4;
		div_c.neg_x  = nx_s4[NW-1] ^ dneg_s4;
		div_c.neg_y  = ny_s4[NW-1] ^ dneg_s4;
		div_c.dsh    = dmag_w << (QW - 1);
		div_c.rem_x  = ax + off_w;
		div_c.rem_y  = ay + off_w;
		div_c.q_x    = '0;
		div_c.q_y    = '0;
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			div_s5 <= div_c;
		end
	end

	assign div = div_s5;

endmodule

`default_nettype wire

@@ rtl/spi_div_cell.sv @@
// ----------------------------------------------------------------------------
// spi_div_cell
// One restoring division step for both coordinates: compares the partial
// remainders with the aligned divisor and hands the result to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_ready,
	input  spi_pkg::spi_div_t up,
	output logic              dn_valid,
	input  logic              dn_ready,
	output spi_pkg::spi_div_t dn
);
	import spi_pkg::*;

	logic     valid_q;
	spi_div_t dn_q;
	spi_div_t nxt;
	logic     ge_x, ge_y;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn       = dn_q;

	// one quotient bit per coordinate
	assign ge_x = up.rem_x >= up.dsh;
	assign ge_y = up.rem_y >= up.dsh;

	always_comb begin
		nxt       = up;
		nxt.rem_x = ge_x ? (up.rem_x - up.dsh) : up.rem_x;
		nxt.rem_y = ge_y ? (up.rem_y - up.dsh) : up.rem_y;
		nxt.q_x   = {up.q_x[QW-2:0], ge_x};
		nxt.q_y   = {up.q_y[QW-2:0], ge_y};
		nxt.dsh   = up.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) begin
			dn_q <= nxt;
		end
	end

endmodule

`default_nettype wire

@@ sim/segment_pair_intersection_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_pair_intersection_core_test
// Drives segment pairs into the core, predicts each rounded crossing in
// wide signed arithmetic, and compares every result in order.
// ----------------------------------------------------------------------------

module segment_pair_intersection_core_test;
	import spi_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 40;

	// one expected result
	typedef struct {
		logic [1:0]           status;
		logic                 crosses;
		logic signed [CW-1:0] cross_x;
		logic signed [CW-1:0] cross_y;
	} crossing_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic out_valid;
	logic out_stall;
	logic signed [CW-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
	logic signed [CW-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
	logic [IW-1:0] a_start_id, a_end_id, b_start_id, b_end_id;
	logic [1:0] status;
	logic crosses;
	logic signed [CW-1:0] cross_x, cross_y;

	crossing_t pending_crossings[$];
	int errors;
	int idle_cycles;
	bit send_gaps;
	bit stall_gaps;

	segment_pair_intersection_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.a_start_x  (a_start_x),
		.a_start_y  (a_start_y),
		.a_end_x    (a_end_x),
		.a_end_y    (a_end_y),
		.b_start_x  (b_start_x),
		.b_start_y  (b_start_y),
		.b_end_x    (b_end_x),
		.b_end_y    (b_end_y),
		.a_start_id (a_start_id),
		.a_end_id   (a_end_id),
		.b_start_id (b_start_id),
		.b_end_id   (b_end_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.crosses    (crosses),
		.cross_x    (cross_x),
		.cross_y    (cross_y)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// side value of a point against a line
	function automatic logic signed [127:0] side_of(logic signed [127:0] a,
			logic signed [127:0] b, logic signed [127:0] c,
			logic signed [127:0] x, logic signed [127:0] y);
		return a * x + b * y + c;
	endfunction

	function automatic bit apart(logic signed [127:0] r1, logic signed [127:0] r2);
		return r1 != 0 && r2 != 0 && (r1[127] == r2[127]);
	endfunction

	// round to nearest: offset away from zero, then truncate
	function automatic logic signed [127:0] round_div(logic signed [127:0] num,
			logic signed [127:0] off, logic signed [127:0] den);
		logic signed [127:0] adj;
		adj = num < 0 ? num - off : num + off;
		return adj / den;
	endfunction

	// expected crossing for one segment pair
	function automatic crossing_t predict_crossing(
			logic signed [CW-1:0] ax1, logic signed [CW-1:0] ay1,
			logic signed [CW-1:0] ax2, logic signed [CW-1:0] ay2,
			logic signed [CW-1:0] bx1, logic signed [CW-1:0] by1,
			logic signed [CW-1:0] bx2, logic signed [CW-1:0] by2,
			logic [IW-1:0] ia1, logic [IW-1:0] ia2,
			logic [IW-1:0] ib1, logic [IW-1:0] ib2);
		crossing_t r;
		logic signed [127:0] x1, y1, x2, y2, x3, y3, x4, y4;
		logic signed [127:0] a1, b1, c1, a2, b2, c2, den, off, px, py;
		r = '{ST_NONE, 1'b0, '0, '0};
		x1 = ax1; y1 = ay1; x2 = ax2; y2 = ay2;
		x3 = bx1; y3 = by1; x4 = bx2; y4 = by2;
		if (ia1 == ib1 || ia1 == ib2 || ia2 == ib1 || ia2 == ib2) begin
			r.status = ST_SHARED;
			return r;
		end
		a1 = y2 - y1;
		b1 = x1 - x2;
		c1 = x2 * y1 - x1 * y2;
		if (apart(side_of(a1, b1, c1, x3, y3), side_of(a1, b1, c1, x4, y4)))
			return r;
		a2 = y4 - y3;
		b2 = x3 - x4;
		c2 = x4 * y3 - x3 * y4;
		if (apart(side_of(a2, b2, c2, x1, y1), side_of(a2, b2, c2, x2, y2)))
			return r;
		den = a1 * b2 - a2 * b1;
		if (den == 0) begin
			r.status = ST_PARALLEL;
			return r;
		end
		off = (den < 0 ? -den : den) >>> 1;
		px = round_div(b1 * c2 - b2 * c1, off, den);
		py = round_div(a2 * c1 - a1 * c2, off, den);
		r.status = ST_CROSS;
		r.crosses = 1'b1;
		r.cross_x = px[CW-1:0];
		r.cross_y = py[CW-1:0];
		return r;
	endfunction

	// random idle burst on the sending side
	task automatic send_gap();
		repeat ($urandom_range(1, 12)) @(negedge clk);
	endtask

	// send one request and wait until it is taken
	task automatic send_pair(logic signed [CW-1:0] ax1, logic signed [CW-1:0] ay1,
			logic signed [CW-1:0] ax2, logic signed [CW-1:0] ay2,
			logic signed [CW-1:0] bx1, logic signed [CW-1:0] by1,
			logic signed [CW-1:0] bx2, logic signed [CW-1:0] by2,
			logic [IW-1:0] ia1, logic [IW-1:0] ia2,
			logic [IW-1:0] ib1, logic [IW-1:0] ib2);
		in_valid <= 1'b1;
		a_start_x <= ax1; a_start_y <= ay1; a_end_x <= ax2; a_end_y <= ay2;
		b_start_x <= bx1; b_start_y <= by1; b_end_x <= bx2; b_end_y <= by2;
		a_start_id <= ia1; a_end_id <= ia2; b_start_id <= ib1; b_end_id <= ib2;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_crossings.push_back(predict_crossing(ax1, ay1, ax2, ay2,
			bx1, by1, bx2, by2, ia1, ia2, ib1, ib2));
		@(negedge clk);
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			send_gap();
		end
	endtask

	// distinct vertex numbers
	task automatic send_plain(logic signed [CW-1:0] ax1, logic signed [CW-1:0] ay1,
			logic signed [CW-1:0] ax2, logic signed [CW-1:0] ay2,
			logic signed [CW-1:0] bx1, logic signed [CW-1:0] by1,
			logic signed [CW-1:0] bx2, logic signed [CW-1:0] by2);
		send_pair(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2, 16'd1, 16'd2, 16'd3, 16'd4);
	endtask

	function automatic logic signed [CW-1:0] rand_coord(int span);
		if (span == 0)
			return CW'($urandom);
		return CW'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_crossings.size() != 0) @(negedge clk);
	endtask

	// directed cases: each status, rounding signs, extremes
	task automatic test_directed();
		localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
		localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
		send_plain(0, 0, 10, 10, 0, 10, 10, 0);
		send_plain(0, 0, 3, 1, 0, 1, 1, 0);
		send_plain(0, 0, -3, -1, 0, -1, -1, 0);
		send_plain(0, 0, 10, 0, 0, 5, 10, 5);
		send_plain(0, 0, 10, 0, 5, 0, 15, 0);
		send_plain(3, 3, 3, 3, 3, 3, 3, 3);
		send_plain(0, 0, 10, 10, 20, 0, 30, -10);
		send_plain(0, 0, 10, 0, 5, 0, 5, 10);
		send_plain(0, 0, 10, 0, 5, 1, 5, 10);
		send_plain(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
		send_plain(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
		send_plain(MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC);
		send_plain(MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC);
		send_pair(0, 0, 10, 10, 0, 10, 10, 0, 16'd7, 16'd8, 16'd7, 16'd9);
		send_pair(0, 0, 10, 10, 0, 10, 10, 0, 16'd7, 16'd8, 16'd9, 16'd8);
		send_pair(0, 0, 10, 10, 0, 10, 10, 0, 16'hFFFF, 16'h0, 16'h1, 16'hFFFF);
		send_pair(0, 0, 10, 10, 0, 10, 10, 0, 16'h0, 16'hFFFF, 16'h0, 16'h1);
		send_pair(0, 0, 10, 10, 0, 10, 10, 0, 16'hAAAA, 16'h5555, 16'h1234, 16'hFEDC);
		send_pair(0, 0, 10, 10, 0, 10, 10, 0, 16'h5, 16'h5, 16'h6, 16'h6);
	endtask

	// random pairs, mostly built so the segments cross
	task automatic test_random(int count);
		logic signed [CW-1:0] c[8];
		logic [IW-1:0] ids[4];
		int span;
		int mode;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 3))
				0: span = 20;
				1: span = 5000;
				2: span = 2000000;
				default: span = 0;
			endcase
			mode = $urandom_range(0, 9);
			foreach (c[i]) c[i] = rand_coord(span);
			if (mode < 6) begin
				// reflect B ends through A's midpoint area so they straddle
				c[6] = c[0] + c[2] - c[4];
				c[7] = c[1] + c[3] - c[5];
				if (span == 0) begin
					c[6] = rand_coord(0);
					c[7] = rand_coord(0);
				end
			end else if (mode == 6) begin
				c[4] = c[0]; c[5] = c[1];
			end else if (mode == 7) begin
				c[6] = c[4] + (c[2] - c[0]);
				c[7] = c[5] + (c[3] - c[1]);
			end
			ids[0] = IW'($urandom); ids[1] = IW'($urandom);
			ids[2] = IW'($urandom); ids[3] = IW'($urandom);
			if ($urandom_range(0, 9) == 0)
				ids[$urandom_range(2, 3)] = ids[$urandom_range(0, 1)];
			send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
				ids[0], ids[1], ids[2], ids[3]);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		crossing_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_crossings.size() == 0) begin
				$display("%0t: unexpected result status=%0d", $realtime, status);
				errors++;
			end else begin
				want = pending_crossings.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, want.status, status);
					errors++;
				end
				if (crosses !== want.crosses) begin
					$display("%0t: crosses expected %0d actual %0d",
						$realtime, want.crosses, crosses);
					errors++;
				end
				if (cross_x !== want.cross_x) begin
					$display("%0t: cross_x expected %0d actual %0d",
						$realtime, want.cross_x, cross_x);
					errors++;
				end
				if (cross_y !== want.cross_y) begin
					$display("%0t: cross_y expected %0d actual %0d",
						$realtime, want.cross_y, cross_y);
					errors++;
				end
			end
		end
	end

	// receiver stall bursts
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_gaps && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no accepted request or result
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		send_gaps = 1'b0;
		stall_gaps = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		a_start_x = '0; a_start_y = '0; a_end_x = '0; a_end_y = '0;
		b_start_x = '0; b_start_y = '0; b_end_x = '0; b_end_y = '0;
		a_start_id = '0; a_end_id = '0; b_start_id = '0; b_end_id = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		send_gaps = 1'b1;
		stall_gaps = 1'b1;
		test_random(500);
		// hold off until the pipeline empties
		wait_drained();
		test_random(500);
		send_gaps = 1'b0;
		stall_gaps = 1'b0;
		test_random(200);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0 && pending_crossings.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
